[hw/rtl/gha_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generational handle allocator package
// Sizes, command codes and memory word layouts shared by the allocator files.
// ----------------------------------------------------------------------------
package gha_pkg;

  localparam int SLOTS   = 256;
  localparam int IDX_W   = 8;
  localparam int GEN_W   = 16;
  localparam int PAY_W   = 32;
  localparam int FRESH_W = 9;
  localparam int CNT_W   = 8;
  localparam int VER_W   = 32;

  localparam logic [1:0] CMD_CREATE  = 2'd0;
  localparam logic [1:0] CMD_DESTROY = 2'd1;
  localparam logic [1:0] CMD_LOOKUP  = 2'd2;
  localparam logic [1:0] CMD_CLEAR   = 2'd3;

  // One slot of the slot memory.
  typedef struct packed {
    logic [GEN_W-1:0] gen;
    logic [PAY_W-1:0] payload;
  } slot_word_t;

  // One entry of the free stack: the freed slot and the generation it will
  // carry when it is handed out again.
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [GEN_W-1:0] gen;
  } stack_word_t;

  // Update request for the occupancy flags.
  typedef struct packed {
    logic             set;
    logic             clr;
    logic             clr_all;
    logic [IDX_W-1:0] idx;
  } occ_cmd_t;

endpackage

[hw/rtl/gha_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocator request channel
// Valid/ready channel carrying one command with its handle and payload.
// ----------------------------------------------------------------------------
interface gha_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [7:0]  slot_index;
  logic [15:0] handle_generation;
  logic [31:0] payload_in;

  modport source (output valid, command, slot_index, handle_generation, payload_in,
                  input ready);
  modport sink   (input valid, command, slot_index, handle_generation, payload_in,
                  output ready);
endinterface

[hw/rtl/gha_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocator result channel
// Valid/ready channel carrying one result per request.
// ----------------------------------------------------------------------------
interface gha_out_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [7:0]  handle_index;
  logic [15:0] handle_gen_out;
  logic [31:0] payload_out;
  logic [7:0]  active_count;
  logic [31:0] version;

  modport source (output valid, ok, handle_index, handle_gen_out, payload_out,
                  active_count, version, input ready);
  modport sink   (input valid, ok, handle_index, handle_gen_out, payload_out,
                  active_count, version, output ready);
endinterface

[hw/rtl/gha_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Simple dual-port RAM
// One write port and one read port, read data registered on read enable.
// ----------------------------------------------------------------------------
module gha_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/gha_occ_flags.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Occupancy flags
// One flag per slot, set on create, cleared on destroy, all cleared at once.
// ----------------------------------------------------------------------------
module gha_occ_flags
  import gha_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  occ_cmd_t         cmd,
  input  logic [IDX_W-1:0] rd_idx,
  output logic             rd_flag
);

  logic [SLOTS-1:0] flags_r;

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr_all) begin
      flags_r <= '0;
    end else if (cmd.set) begin
      flags_r[cmd.idx] <= 1'b1;
    end else if (cmd.clr) begin
      flags_r[cmd.idx] <= 1'b0;
    end
  end

  assign rd_flag = flags_r[rd_idx];

endmodule

[hw/rtl/generational_handle_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generational handle allocator
// Slot map handing out index/generation handles with a LIFO free list.
// ----------------------------------------------------------------------------
// Each request passes through the idle and execute states: in the cycle it
// is accepted the slot memory and the free-stack memory are read, and in the
// execute state, once the registered read data is back and the output
// register can take a result, the result is formed and the slot, stack and
// occupancy state are written back. The next request can be accepted while
// the previous result still waits in the output register, and no clearing
// pass is needed after reset: the occupancy flags clear at once.
module generational_handle_allocator
  import gha_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  gha_in_if.sink    in_if,
  gha_out_if.source out_if
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_r, state_nxt;

  // Request held for the execute state.
  logic [1:0]       cmd_r;
  logic [IDX_W-1:0] idx_r;
  logic [GEN_W-1:0] gen_r;
  logic [PAY_W-1:0] pay_r;

  // Table state.
  logic [CNT_W-1:0]   stk_cnt_r, stk_cnt_nxt;
  logic [FRESH_W-1:0] fresh_r, fresh_nxt;
  logic [CNT_W-1:0]   live_r, live_nxt;
  logic [VER_W-1:0]   ver_r, ver_nxt;

  // Output register.
  logic             out_valid_r;
  logic             res_ok_r, res_ok_nxt;
  logic [IDX_W-1:0] res_idx_r, res_idx_nxt;
  logic [GEN_W-1:0] res_gen_r, res_gen_nxt;
  logic [PAY_W-1:0] res_pay_r, res_pay_nxt;
  logic [CNT_W-1:0] res_live_r;
  logic [VER_W-1:0] res_ver_r;

  logic accept, fire;

  logic                   slot_we;
  logic [IDX_W-1:0]       slot_waddr;
  slot_word_t             slot_wdata;
  logic [$bits(slot_word_t)-1:0] slot_rdata;
  slot_word_t             slot_rd;

  logic                   stk_we;
  stack_word_t            stk_wdata;
  logic [$bits(stack_word_t)-1:0] stk_rdata;
  stack_word_t            stk_rd;

  occ_cmd_t occ_cmd;
  logic     occ_rd;

  logic             hit;
  logic [GEN_W-1:0] bump_gen;

  assign accept      = in_if.valid && in_if.ready;
  assign in_if.ready = (state_r == ST_IDLE);
  assign fire        = (state_r == ST_EXEC) && (!out_valid_r || out_if.ready);

  assign slot_rd = slot_word_t'(slot_rdata);
  assign stk_rd  = stack_word_t'(stk_rdata);

  gha_ram #(
    .DEPTH (SLOTS),
    .WIDTH ($bits(slot_word_t))
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .re    (accept),
    .raddr (in_if.slot_index),
    .rdata (slot_rdata)
  );

  // The top of the stack is read speculatively; it is only used when the
  // stack is not empty.
  gha_ram #(
    .DEPTH (SLOTS),
    .WIDTH ($bits(stack_word_t))
  ) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_cnt_r),
    .wdata (stk_wdata),
    .re    (accept),
    .raddr (stk_cnt_r - CNT_W'(1)),
    .rdata (stk_rdata)
  );

  gha_occ_flags u_occ (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (occ_cmd),
    .rd_idx  (idx_r),
    .rd_flag (occ_rd)
  );

  always_comb begin
    hit = (idx_r != '0) && ({1'b0, idx_r} < fresh_r) && occ_rd && (slot_rd.gen == gen_r);
    // The stored generation equals gen_r whenever the handle is valid.
    bump_gen = gen_r + GEN_W'(1);
    if (bump_gen == '0) begin
      bump_gen = GEN_W'(1);
    end

    state_nxt   = state_r;
    stk_cnt_nxt = stk_cnt_r;
    fresh_nxt   = fresh_r;
    live_nxt    = live_r;
    ver_nxt     = ver_r;

    res_ok_nxt  = 1'b0;
    res_idx_nxt = idx_r;
    res_gen_nxt = gen_r;
    res_pay_nxt = '0;

    slot_we            = 1'b0;
    slot_waddr         = idx_r;
    slot_wdata.gen     = bump_gen;
    slot_wdata.payload = '0;
    stk_we             = 1'b0;
    stk_wdata.idx      = idx_r;
    stk_wdata.gen      = bump_gen;
    occ_cmd            = '0;
    occ_cmd.idx        = idx_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (fire) begin
          state_nxt = ST_IDLE;
          case (cmd_r)
            CMD_CREATE: begin
              if (stk_cnt_r != '0) begin
                res_ok_nxt  = 1'b1;
                res_idx_nxt = stk_rd.idx;
                res_gen_nxt = stk_rd.gen;
                stk_cnt_nxt = stk_cnt_r - CNT_W'(1);
              end else if (fresh_r < FRESH_W'(SLOTS)) begin
                res_ok_nxt  = 1'b1;
                res_idx_nxt = fresh_r[IDX_W-1:0];
                res_gen_nxt = GEN_W'(1);
                fresh_nxt   = fresh_r + FRESH_W'(1);
              end else begin
                res_idx_nxt = '0;
                res_gen_nxt = '0;
              end
              if (res_ok_nxt) begin
                slot_we            = 1'b1;
                slot_waddr         = res_idx_nxt;
                slot_wdata.gen     = res_gen_nxt;
                slot_wdata.payload = pay_r;
                occ_cmd.set        = 1'b1;
                occ_cmd.idx        = res_idx_nxt;
                live_nxt           = live_r + CNT_W'(1);
                ver_nxt            = ver_r + VER_W'(1);
              end
            end
            CMD_DESTROY: begin
              if (hit) begin
                res_ok_nxt  = 1'b1;
                slot_we     = 1'b1;
                stk_we      = 1'b1;
                occ_cmd.clr = 1'b1;
                stk_cnt_nxt = stk_cnt_r + CNT_W'(1);
                if (live_r != '0) begin
                  live_nxt = live_r - CNT_W'(1);
                end
                ver_nxt = ver_r + VER_W'(1);
              end
            end
            CMD_LOOKUP: begin
              if (hit) begin
                res_ok_nxt  = 1'b1;
                res_pay_nxt = slot_rd.payload;
              end
            end
            default: begin
              res_ok_nxt      = 1'b1;
              occ_cmd.clr_all = 1'b1;
              stk_cnt_nxt     = '0;
              fresh_nxt       = FRESH_W'(1);
              live_nxt        = '0;
              ver_nxt         = ver_r + VER_W'(1);
            end
          endcase
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      stk_cnt_r   <= '0;
      fresh_r     <= FRESH_W'(1);
      live_r      <= '0;
      ver_r       <= VER_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      stk_cnt_r <= stk_cnt_nxt;
      fresh_r   <= fresh_nxt;
      live_r    <= live_nxt;
      ver_r     <= ver_nxt;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_if.command;
      idx_r <= in_if.slot_index;
      gen_r <= in_if.handle_generation;
      pay_r <= in_if.payload_in;
    end
    if (fire) begin
      res_ok_r   <= res_ok_nxt;
      res_idx_r  <= res_idx_nxt;
      res_gen_r  <= res_gen_nxt;
      res_pay_r  <= res_pay_nxt;
      res_live_r <= live_nxt;
      res_ver_r  <= ver_nxt;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.ok             = res_ok_r;
  assign out_if.handle_index   = res_idx_r;
  assign out_if.handle_gen_out = res_gen_r;
  assign out_if.payload_out    = res_pay_r;
  assign out_if.active_count   = res_live_r;
  assign out_if.version        = res_ver_r;

endmodule

[test/gha_reply_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocator reply checker
// Watches the request and result channels of the generational handle
// allocator. It keeps its own copy of the slot table, works out the reply
// for every accepted request and compares each accepted result with the
// oldest reply still due.
// ----------------------------------------------------------------------------
module gha_reply_checker
  import gha_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  gha_in_if    req,
  gha_out_if   rsp,
  output int   outstanding,
  output int   mismatches,
  output int   full_refusals
);

  typedef struct packed {
    logic             ok;
    logic [IDX_W-1:0] idx;
    logic [GEN_W-1:0] gen;
    logic [PAY_W-1:0] payload;
    logic [CNT_W-1:0] active;
    logic [VER_W-1:0] version;
  } reply_t;

  logic [PAY_W-1:0]   shadow_payload [SLOTS];
  logic [GEN_W-1:0]   shadow_gen [SLOTS];
  bit                 shadow_busy [SLOTS];
  logic [IDX_W-1:0]   shadow_stack [SLOTS];
  int unsigned        stack_depth;
  logic [FRESH_W-1:0] next_fresh;
  logic [CNT_W-1:0]   live;
  logic [VER_W-1:0]   changes;

  reply_t replies_due [$];
  reply_t oldest;
  int     reply_no;

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    // Past the first 40, mismatches are only counted.
    if (mismatches <= 40) begin
      $display("%0t: reply %0d, %s is 0x%0h, expected 0x%0h", $time, reply_no, what, got,
               want);
    end
  endtask

  function automatic logic handle_live(logic [IDX_W-1:0] idx, logic [GEN_W-1:0] gen);
    return idx != '0 && idx < next_fresh && shadow_busy[idx] && shadow_gen[idx] == gen;
  endfunction

  // Applies one request to the shadow table and returns the reply it causes.
  function automatic reply_t predict_reply(logic [1:0] cmd, logic [IDX_W-1:0] idx,
                                           logic [GEN_W-1:0] gen, logic [PAY_W-1:0] pay);
    reply_t           r;
    logic [IDX_W-1:0] slot;
    logic [GEN_W-1:0] bumped;
    logic             got;
    r     = '0;
    r.idx = idx;
    r.gen = gen;
    slot  = '0;
    case (cmd)
      CMD_CREATE: begin
        got = 1'b1;
        if (stack_depth != 0) begin
          stack_depth--;
          slot = shadow_stack[stack_depth];
        end else if (next_fresh < SLOTS) begin
          slot = next_fresh[IDX_W-1:0];
          next_fresh++;
          shadow_gen[slot] = GEN_W'(1);
        end else begin
          got = 1'b0;
        end
        if (got) begin
          shadow_payload[slot] = pay;
          shadow_busy[slot]    = 1'b1;
          live++;
          changes++;
          r.ok  = 1'b1;
          r.idx = slot;
          r.gen = shadow_gen[slot];
        end else begin
          r.idx = '0;
          r.gen = '0;
          full_refusals++;
        end
      end
      CMD_DESTROY: begin
        if (handle_live(idx, gen)) begin
          // The generation skips zero so that a zero handle never matches.
          bumped = shadow_gen[idx] + 1'b1;
          if (bumped == '0) begin
            bumped = GEN_W'(1);
          end
          shadow_gen[idx]     = bumped;
          shadow_payload[idx] = '0;
          shadow_busy[idx]    = 1'b0;
          if (stack_depth < SLOTS) begin
            shadow_stack[stack_depth] = idx;
            stack_depth++;
          end
          if (live != 0) begin
            live--;
          end
          changes++;
          r.ok = 1'b1;
        end
      end
      CMD_LOOKUP: begin
        if (handle_live(idx, gen)) begin
          r.ok      = 1'b1;
          r.payload = shadow_payload[idx];
        end
      end
      CMD_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) shadow_busy[i] = 1'b0;
        stack_depth = 0;
        next_fresh  = FRESH_W'(1);
        live        = '0;
        changes++;
        r.ok = 1'b1;
      end
    endcase
    r.active  = live;
    r.version = changes;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) shadow_busy[i] = 1'b0;
      stack_depth = 0;
      next_fresh  = FRESH_W'(1);
      live        = '0;
      changes     = VER_W'(1);
      replies_due.delete();
      reply_no    = 0;
      outstanding <= 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        reply_no++;
        if (replies_due.size() == 0) begin
          report_mismatch("unexpected result, version", rsp.version, '0);
        end else begin
          oldest = replies_due.pop_front();
          if (rsp.ok !== oldest.ok)
            report_mismatch("ok", rsp.ok, oldest.ok);
          if (rsp.handle_index !== oldest.idx)
            report_mismatch("handle_index", rsp.handle_index, oldest.idx);
          if (rsp.handle_gen_out !== oldest.gen)
            report_mismatch("handle_gen_out", rsp.handle_gen_out, oldest.gen);
          if (rsp.payload_out !== oldest.payload)
            report_mismatch("payload_out", rsp.payload_out, oldest.payload);
          if (rsp.active_count !== oldest.active)
            report_mismatch("active_count", rsp.active_count, oldest.active);
          if (rsp.version !== oldest.version)
            report_mismatch("version", rsp.version, oldest.version);
        end
      end
      if (req.valid && req.ready) begin
        replies_due.insert(replies_due.size(),
                           predict_reply(req.command, req.slot_index,
                                         req.handle_generation, req.payload_in));
      end
      outstanding <= replies_due.size();
    end
  end

endmodule

[test/generational_handle_allocator_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generational handle allocator testbench
// Drives create, destroy, lookup and clear requests with random pacing on
// both channels: a directed opening, one slot taken round the free stack
// several times, then random phases that fill the table, churn the free
// stack and mix in stale and malformed handles. A separate checker predicts
// and compares every result.
// ----------------------------------------------------------------------------
module generational_handle_allocator_test;
  import gha_pkg::*;

  localparam int STALL_LIMIT     = 2000;
  localparam int HOLD_OFF_CYCLES = 400;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [GEN_W-1:0] gen;
  } handle_t;

  logic clk = 1'b0;
  logic rst_n;

  gha_in_if  req_ch ();
  gha_out_if rsp_ch ();

  int outstanding;
  int mismatches;
  int full_refusals;

  handle_t    live_handles [$];
  logic [1:0] sent_cmds [$];
  int         cmd_counts [4];
  int         idle_cycles;
  int         burst_left;
  bit         paced;
  bit         long_hold_wanted;

  generational_handle_allocator u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (req_ch),
    .out_if (rsp_ch)
  );

  gha_reply_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req           (req_ch),
    .rsp           (rsp_ch),
    .outstanding   (outstanding),
    .mismatches    (mismatches),
    .full_refusals (full_refusals)
  );

  always #4 clk = ~clk;

  // Receiver: stretches always, mostly and half ready and mostly stalled, plus
  // one long hold-off so that the allocator backs up into the request channel.
  initial begin
    int mode;
    int stretch;
    rsp_ch.ready <= 1'b0;
    forever begin
      if (long_hold_wanted) begin
        long_hold_wanted = 1'b0;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      mode    = $urandom_range(0, 3);
      stretch = $urandom_range(4, 60);
      repeat (stretch) begin
        case (mode)
          0:       rsp_ch.ready <= 1'b1;
          1:       rsp_ch.ready <= ($urandom_range(0, 3) != 0);
          2:       rsp_ch.ready <= ($urandom_range(0, 3) == 0);
          default: rsp_ch.ready <= ($urandom_range(0, 1) == 1);
        endcase
        @(posedge clk);
      end
    end
  end

  // Handshakes are settled by the falling edge, so the handle pool is kept up
  // to date there, clear of the rising edge where stimulus reads it.
  always @(negedge clk) begin
    if (rst_n && req_ch.valid && req_ch.ready) begin
      sent_cmds.insert(sent_cmds.size(), req_ch.command);
    end
    if (rst_n && rsp_ch.valid && rsp_ch.ready && sent_cmds.size() != 0) begin
      if (sent_cmds.pop_front() == CMD_CREATE && rsp_ch.ok) begin
        live_handles.insert(live_handles.size(),
                            {rsp_ch.handle_index, rsp_ch.handle_gen_out});
      end
    end
  end

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Timed out: %0d cycles without a request or result moving", STALL_LIMIT);
      $display("FAIL generational_handle_allocator");
      $finish;
    end
  end

  task automatic send_request(logic [1:0] cmd, logic [IDX_W-1:0] idx,
                              logic [GEN_W-1:0] gen, logic [PAY_W-1:0] pay);
    req_ch.valid             <= 1'b1;
    req_ch.command           <= cmd;
    req_ch.slot_index        <= idx;
    req_ch.handle_generation <= gen;
    req_ch.payload_in        <= pay;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    cmd_counts[cmd]++;
    if (paced) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        if ($urandom_range(0, 9) < 7) begin
          req_ch.valid <= 1'b0;
          repeat ($urandom_range(1, 12)) @(posedge clk);
        end
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic wait_for_replies();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Destroys and lookups mostly use handles that were handed out, some with a
  // generation one off; the rest carry random handles.
  task automatic random_request(int w_create, int w_destroy, int w_lookup, int w_clear);
    int         roll;
    int         pick;
    handle_t    h;
    logic [1:0] cmd;
    roll = $urandom_range(0, w_create + w_destroy + w_lookup + w_clear - 1);
    if (roll < w_create) begin
      cmd = CMD_CREATE;
    end else if (roll < w_create + w_destroy) begin
      cmd = CMD_DESTROY;
    end else if (roll < w_create + w_destroy + w_lookup) begin
      cmd = CMD_LOOKUP;
    end else begin
      cmd = CMD_CLEAR;
    end
    h.idx = IDX_W'($urandom_range(0, 255));
    h.gen = GEN_W'($urandom_range(0, 65535));
    if ((cmd == CMD_DESTROY || cmd == CMD_LOOKUP) && live_handles.size() != 0 &&
        $urandom_range(0, 9) < 8) begin
      pick = $urandom_range(0, live_handles.size() - 1);
      h    = live_handles[pick];
      case ($urandom_range(0, 15))
        0:       h.gen = h.gen + 1'b1;
        1:       h.gen = h.gen - 1'b1;
        default: if (cmd == CMD_DESTROY) live_handles.delete(pick);
      endcase
    end
    if (cmd == CMD_CLEAR) begin
      live_handles.delete();
    end
    send_request(cmd, h.idx, h.gen, $urandom());
  endtask

  initial begin
    rst_n                    <= 1'b0;
    req_ch.valid             <= 1'b0;
    req_ch.command           <= CMD_CREATE;
    req_ch.slot_index        <= '0;
    req_ch.handle_generation <= '0;
    req_ch.payload_in        <= '0;
    paced = 1'b1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening: empty table, payload extremes, wrong generations,
    // indices past the fresh mark and at zero, LIFO reuse and clear.
    send_request(CMD_LOOKUP,  8'd0,   16'd0,      32'd0);
    send_request(CMD_CREATE,  8'd0,   16'd0,      32'h0000_0000);
    send_request(CMD_CREATE,  8'hff,  16'hffff,   32'hffff_ffff);
    send_request(CMD_LOOKUP,  8'd1,   16'd1,      32'd0);
    send_request(CMD_LOOKUP,  8'd2,   16'd1,      32'd0);
    send_request(CMD_LOOKUP,  8'd2,   16'hffff,   32'd0);
    send_request(CMD_LOOKUP,  8'd3,   16'd1,      32'd0);
    send_request(CMD_LOOKUP,  8'd0,   16'd1,      32'd0);
    send_request(CMD_DESTROY, 8'hff,  16'hffff,   32'hffff_ffff);
    send_request(CMD_DESTROY, 8'd1,   16'd1,      32'd0);
    send_request(CMD_DESTROY, 8'd1,   16'd1,      32'd0);
    send_request(CMD_LOOKUP,  8'd1,   16'd2,      32'd0);
    send_request(CMD_CREATE,  8'd0,   16'd0,      32'ha5a5_a5a5);
    send_request(CMD_LOOKUP,  8'd1,   16'd2,      32'd0);
    send_request(CMD_DESTROY, 8'd2,   16'd1,      32'd0);
    send_request(CMD_DESTROY, 8'd1,   16'd2,      32'd0);
    send_request(CMD_CREATE,  8'd0,   16'd0,      $urandom());
    send_request(CMD_CREATE,  8'd0,   16'd0,      $urandom());
    send_request(CMD_CLEAR,   8'd0,   16'd0,      32'd0);
    send_request(CMD_LOOKUP,  8'd1,   16'd3,      32'd0);
    send_request(CMD_CREATE,  8'd0,   16'd0,      $urandom());
    send_request(CMD_DESTROY, 8'd0,   16'd0,      32'd0);

    // Slot 1 alone is created and destroyed back to back; every create after
    // the first takes it off the free stack with the next generation.
    paced = 1'b0;
    send_request(CMD_CLEAR, 8'd0, 16'd0, 32'd0);
    for (int g = 1; g <= 8; g++) begin
      send_request(CMD_CREATE, IDX_W'($urandom()), GEN_W'($urandom()), $urandom());
      send_request(CMD_DESTROY, 8'd1, GEN_W'(g), $urandom());
    end
    send_request(CMD_CREATE, 8'd0, 16'd0, $urandom());
    paced = 1'b1;
    wait_for_replies();
    live_handles.delete();

    // Mixed traffic, with the receiver holding off for a long stretch.
    long_hold_wanted = 1'b1;
    repeat (400) random_request(40, 25, 33, 2);
    wait_for_replies();

    // From an empty table: fill past full, churn the free stack, then mix.
    random_request(0, 0, 0, 1);
    repeat (450) random_request(85, 5, 10, 0);
    repeat (350) random_request(20, 50, 30, 0);
    repeat (200) random_request(40, 25, 33, 2);
    wait_for_replies();
    repeat (16) @(posedge clk);

    $display("Requests: %0d creates (%0d refused on a full table), %0d destroys, %0d lookups,",
             cmd_counts[CMD_CREATE], full_refusals, cmd_counts[CMD_DESTROY],
             cmd_counts[CMD_LOOKUP]);
    $display("%0d clears; one slot was recycled through the free stack several times.",
             cmd_counts[CMD_CLEAR]);
    if (mismatches == 0) begin
      $display("PASS generational_handle_allocator");
    end else begin
      $display("FAIL generational_handle_allocator");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/gha_pkg.sv
hw/rtl/gha_in_if.sv
hw/rtl/gha_out_if.sv
hw/rtl/gha_ram.sv
hw/rtl/gha_occ_flags.sv
hw/rtl/generational_handle_allocator.sv
test/gha_reply_checker.sv
test/generational_handle_allocator_test.sv
